// File: src/mptm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mptm_pkg
// Shared types, constants and arithmetic helpers of the prepaid time meter.
// ----------------------------------------------------------------------------
package mptm_pkg;

  localparam int CHANNELS_DEF = 10;

  localparam int TIME_W   = 14;
  localparam int GLYPH_W  = 7;
  localparam int WEIGHT_W = 8;
  localparam int FLASH_W  = 8;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0]   TIME_CAP     = 14'd9999;
  localparam logic [WEIGHT_W-1:0] PLAIN_WEIGHT = 8'd10;
  localparam logic [FLASH_W-1:0]  FLASH_PERIOD = 8'd10;
  localparam logic [FLASH_W-1:0]  FLASH_HALF   = 8'd5;

  localparam logic [GLYPH_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [GLYPH_W-1:0] ASCII_SPACE = 7'h20;
  localparam logic [GLYPH_W-1:0] ASCII_DASH  = 7'h2d;

  // divider: 16 quotient bits, two per cycle
  localparam int DIV_NUM_W = 16;
  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CURRENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OC_MULTIPLE = 2'd2;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_METER   = 2'd1,
    ACT_DISPLAY = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  channel;
    logic [9:0]  amount;
    logic        fuse_ok;
    logic        over_current;
    logic [11:0] current_sample;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  remaining_time;
    logic [GLYPH_W-1:0] glyph_hundreds;
    logic [GLYPH_W-1:0] glyph_tens;
    logic [GLYPH_W-1:0] glyph_units;
    logic               relay_on;
    logic               save_request;
  } out_item_t;

  // floor(x / 10), exact for every 16-bit x
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    begin
      p = 32'(x) * 32'd52429;
      return p[31:19];
    end
  endfunction

  // x * 10 by shift and add
  function automatic logic [15:0] times10(input logic [11:0] x);
    begin
      return 16'({x, 3'b000}) + 16'({x, 1'b0});
    end
  endfunction

endpackage

// File: src/multichannel_prepaid_time_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_prepaid_time_meter
// Per-channel prepaid time store with credit, metering and display glyphs.
// ----------------------------------------------------------------------------
// One item at a time: an accepted item goes through S_EVAL, S_APPLY, S_DIG1,
// S_DIG2 and S_DONE to the result register, and the next item can be accepted
// in the cycle after that result is loaded. A meter tick in power mode with the
// fuse good, no over current and the current above base runs the shared restoring
// divider (two quotient bits a cycle over 16 bits) in S_DIV. Channel times and
// last first glyphs live in small synchronous memories, read when the item is
// accepted and written back when its result is loaded. After reset every
// store reads zero at once. A finished result may wait in the output register
// while the next item is taken.
module multichannel_prepaid_time_meter
  import mptm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH_ALL = 5'(CHANNELS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_APPLY = 7'b0001000,
    S_DIG1  = 7'b0010000,
    S_DIG2  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic        power_mode;
  logic [11:0] base_current;
  logic [7:0]  oc_multiple;

  // memories
  logic [TIME_W-1:0]  credit_mem [CHANNELS];
  logic [GLYPH_W-1:0] glyph_mem  [CHANNELS];
  logic [CHANNELS-1:0] credit_vld;
  logic [CHANNELS-1:0] glyph_vld;
  logic [TIME_W-1:0]  rd_credit;
  logic [GLYPH_W-1:0] rd_glyph;
  logic               rd_credit_vld;
  logic               rd_glyph_vld;
  logic [CH_W-1:0]    rd_addr;
  logic [CH_W-1:0]    wr_addr;

  // item context
  in_item_t           item;
  logic               in_range;
  logic               clear_all;
  logic [TIME_W-1:0]  cred;
  logic [GLYPH_W-1:0] glyph_old;
  logic [WEIGHT_W-1:0] weight;
  logic [FLASH_W-1:0] flash_counter;

  // divider
  logic [DIV_NUM_W-1:0] div_num, div_num_next;
  logic [11:0]          div_rem, div_rem_next;
  logic [11:0]          div_den;
  logic [WEIGHT_W-1:0]  div_q, div_q_next;
  logic [DIV_CNT_W-1:0] div_cnt;

  // results of the apply step
  logic [TIME_W-1:0]  new_cred, new_cred_next;
  logic               save, save_next;
  logic               relay, relay_next;
  logic [GLYPH_W-1:0] g0, g0_next, g1, g1_next, g2, g2_next;
  logic               use_digits, use_digits_next;
  logic               credit_we, credit_we_next;
  logic               glyph_we, glyph_we_next;
  logic               wipe_all, wipe_all_next;
  logic [FLASH_W-1:0] flash_next;
  logic [10:0]        mins;

  // digit split
  logic [7:0]  tens_all;
  logic [12:0] tens_all_q;
  logic [3:0]  units_d, tens_d, hund_d;
  logic [12:0] hund_all_q;
  logic [4:0]  hund_all;
  logic [10:0] tens_all_x10;
  logic [7:0]  hund_all_x10;

  logic [FLASH_W-1:0] fc1;
  logic [14:0]        add_sum;
  logic [12:0]        mins_q;
  logic [GLYPH_W-1:0] g0_final, g1_final, g2_final;
  logic               load_out;
  logic               item_in_range;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      power_mode   <= 1'b0;
      base_current <= 12'd1;
      oc_multiple  <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POWER_MODE:   power_mode   <= cfg_data[0];
        CFG_BASE_CURRENT: base_current <= cfg_data;
        CFG_OC_MULTIPLE:  oc_multiple  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------- memories
  assign item_in_range = ({1'b0, in_item.channel} < CH_ALL);
  assign rd_addr = item_in_range ? in_item.channel[CH_W-1:0] : '0;
  assign wr_addr = item.channel[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rd_credit     <= credit_mem[rd_addr];
      rd_glyph      <= glyph_mem[rd_addr];
      rd_credit_vld <= credit_vld[rd_addr];
      rd_glyph_vld  <= glyph_vld[rd_addr];
    end
    if (load_out && credit_we) begin
      credit_mem[wr_addr] <= new_cred;
    end
    if (load_out && glyph_we) begin
      glyph_mem[wr_addr] <= g0_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_vld <= '0;
      glyph_vld  <= '0;
    end else if (load_out) begin
      if (wipe_all) begin
        credit_vld <= '0;
      end else if (credit_we) begin
        credit_vld[wr_addr] <= 1'b1;
      end
      if (glyph_we) begin
        glyph_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- sequencer
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (in_range && item.action == ACT_METER && power_mode && !item.over_current &&
            item.fuse_ok && item.current_sample > base_current) begin
          state_next = S_DIV;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_DIV:   if (div_cnt == DIV_LAST) state_next = S_APPLY;
      S_APPLY: state_next = S_DIG1;
      S_DIG1:  state_next = S_DIG2;
      S_DIG2:  state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the item and the entries read for it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item      <= in_item;
      in_range  <= item_in_range;
      clear_all <= ({1'b0, in_item.channel} == CH_ALL);
    end
    if (state == S_EVAL) begin
      cred      <= rd_credit_vld ? rd_credit : '0;
      glyph_old <= rd_glyph_vld ? rd_glyph : '0;
      if (!power_mode) begin
        weight <= PLAIN_WEIGHT;
      end else if (item.over_current) begin
        weight <= 8'(times10({4'd0, oc_multiple}));
      end else begin
        weight <= PLAIN_WEIGHT;
      end
    end else if (state == S_DIV && div_cnt == DIV_LAST) begin
      weight <= div_q_next;
    end
  end

  // ---------------------------------------------------------------- divider
  always_comb begin
    logic [12:0]          t;
    logic [11:0]          r;
    logic [DIV_NUM_W-1:0] n;
    logic [WEIGHT_W-1:0]  q;
    r = div_rem;
    n = div_num;
    q = div_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {r, n[DIV_NUM_W-1]};
      if (t >= {1'b0, div_den}) begin
        r = 12'(t - {1'b0, div_den});
        q = {q[WEIGHT_W-2:0], 1'b1};
      end else begin
        r = t[11:0];
        q = {q[WEIGHT_W-2:0], 1'b0};
      end
      n = {n[DIV_NUM_W-2:0], 1'b0};
    end
    div_rem_next = r;
    div_num_next = n;
    div_q_next   = q;
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      div_num <= times10(item.current_sample);
      div_rem <= '0;
      div_q   <= '0;
      div_den <= (base_current == 12'd0) ? 12'd1 : base_current;
      div_cnt <= '0;
    end else if (state == S_DIV) begin
      div_num <= div_num_next;
      div_rem <= div_rem_next;
      div_q   <= div_q_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // ------------------------------------------------------------ apply step
  assign fc1     = flash_counter + 1'b1;
  assign add_sum = 15'(cred) + 15'(times10({2'd0, item.amount}));
  assign mins_q  = div10({2'd0, cred});

  always_comb begin
    new_cred_next   = '0;
    save_next       = 1'b0;
    relay_next      = 1'b0;
    g0_next         = '0;
    g1_next         = '0;
    g2_next         = '0;
    use_digits_next = 1'b0;
    credit_we_next  = 1'b0;
    glyph_we_next   = 1'b0;
    wipe_all_next   = 1'b0;
    flash_next      = flash_counter;
    case (item.action)
      ACT_CLEAR: begin
        if (clear_all) begin
          wipe_all_next = 1'b1;
          save_next     = 1'b1;
        end else if (in_range) begin
          credit_we_next = 1'b1;
          save_next      = 1'b1;
        end
      end
      ACT_ADD: begin
        if (in_range) begin
          new_cred_next  = (add_sum > 15'(TIME_CAP)) ? TIME_CAP : add_sum[TIME_W-1:0];
          save_next      = 1'b1;
          credit_we_next = 1'b1;
        end
      end
      ACT_METER: begin
        if (in_range) begin
          credit_we_next = 1'b1;
          if (cred > TIME_W'(weight)) begin
            new_cred_next = cred - TIME_W'(weight);
          end else begin
            save_next = (cred != '0);
          end
        end
      end
      ACT_DISPLAY: begin
        if (in_range) begin
          credit_we_next = 1'b1;
          glyph_we_next  = 1'b1;
          flash_next     = fc1;
          new_cred_next  = cred;
          if (item.fuse_ok) begin
            if (cred < TIME_W'(10)) begin
              if (fc1 >= FLASH_PERIOD) begin
                flash_next = '0;
                g0_next    = glyph_old;
              end else if (fc1 >= FLASH_HALF) begin
                g0_next = ASCII_SPACE;
              end else begin
                g0_next = ASCII_ZERO + GLYPH_W'(item.channel);
              end
              g1_next = ASCII_SPACE;
              g2_next = ASCII_SPACE;
            end else begin
              relay_next = 1'b1;
              // blank phases of the flash cycle while over current
              if (item.over_current &&
                  (fc1 == 8'd0 || fc1 == 8'd1 || fc1 == 8'd2 ||
                   fc1 == 8'd5 || fc1 == 8'd6 || fc1 == 8'd7)) begin
                g0_next = ASCII_SPACE;
                g1_next = ASCII_SPACE;
                g2_next = ASCII_SPACE;
              end else begin
                use_digits_next = 1'b1;
              end
            end
          end else begin
            g0_next       = ASCII_DASH;
            g1_next       = ASCII_DASH;
            g2_next       = ASCII_DASH;
            new_cred_next = '0;
            save_next     = (cred != '0);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      new_cred   <= new_cred_next;
      save       <= save_next;
      relay      <= relay_next;
      g0         <= g0_next;
      g1         <= g1_next;
      g2         <= g2_next;
      use_digits <= use_digits_next;
      credit_we  <= credit_we_next;
      glyph_we   <= glyph_we_next;
      wipe_all   <= wipe_all_next;
      mins       <= mins_q[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_counter <= '0;
    end else if (state == S_APPLY) begin
      flash_counter <= flash_next;
    end
  end

  // ------------------------------------------------------------ digit split
  assign tens_all_q   = div10({5'd0, mins});
  assign tens_all_x10 = 11'({tens_all_q[7:0], 3'b000}) + 11'({tens_all_q[7:0], 1'b0});
  assign hund_all_q   = div10({8'd0, tens_all});
  assign hund_all     = hund_all_q[4:0];
  assign hund_all_x10 = 8'({hund_all, 3'b000}) + 8'({hund_all, 1'b0});

  always_ff @(posedge clk) begin
    if (state == S_DIG1) begin
      tens_all <= tens_all_q[7:0];
      units_d  <= 4'(mins - tens_all_x10);
    end
    if (state == S_DIG2) begin
      tens_d <= 4'(tens_all - hund_all_x10);
      hund_d <= (hund_all >= 5'd10) ? 4'(hund_all - 5'd10) : hund_all[3:0];
    end
  end

  assign g0_final = use_digits ? ASCII_ZERO + GLYPH_W'(hund_d)  : g0;
  assign g1_final = use_digits ? ASCII_ZERO + GLYPH_W'(tens_d)  : g1;
  assign g2_final = use_digits ? ASCII_ZERO + GLYPH_W'(units_d) : g2;

  // ---------------------------------------------------------- result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.remaining_time <= new_cred;
      out_item.glyph_hundreds <= g0_final;
      out_item.glyph_tens     <= g1_final;
      out_item.glyph_units    <= g2_final;
      out_item.relay_on       <= relay;
      out_item.save_request   <= save;
    end
  end

endmodule

// File: test/multichannel_prepaid_time_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_prepaid_time_meter_tb
// Drives credit, meter, display and clear beats into the prepaid time meter
// under several register settings, predicts every result in a scoreboard and
// compares each returned beat field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module multichannel_prepaid_time_meter_tb;
  import mptm_pkg::*;

  localparam int N_CH         = CHANNELS_DEF;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 111;

  class meter_scoreboard;
    logic              cfg_power;
    logic [CFG_W-1:0]  cfg_base;
    logic [7:0]        cfg_multiple;
    logic [TIME_W-1:0] credit_tenths [N_CH];
    logic [7:0]        last_first_glyph [N_CH];
    logic [FLASH_W-1:0] flash_count;
    out_item_t         readouts_due [$];
    int                errors;
    int                n_checked;
    int                n_saves;
    int                n_by_action [4];

    function new();
      cfg_power    = 1'b0;
      cfg_base     = 12'd1;
      cfg_multiple = 8'd1;
      flash_count  = '0;
      foreach (credit_tenths[i]) begin
        credit_tenths[i]    = '0;
        last_first_glyph[i] = '0;
      end
      errors    = 0;
      n_checked = 0;
      n_saves   = 0;
      foreach (n_by_action[i]) n_by_action[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_POWER_MODE:   cfg_power = data[0];
        CFG_BASE_CURRENT: cfg_base = data;
        CFG_OC_MULTIPLE:  cfg_multiple = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] charge_weight(in_item_t it);
      logic [CFG_W-1:0] divisor;
      if (!cfg_power) return PLAIN_WEIGHT;
      if (it.over_current) return 8'(int'(cfg_multiple) * 10);
      // zero base divides as one
      divisor = (cfg_base == '0) ? 12'd1 : cfg_base;
      if (it.fuse_ok && it.current_sample > cfg_base)
        return 8'((int'(it.current_sample) * 10) / int'(divisor));
      return PLAIN_WEIGHT;
    endfunction

    function out_item_t settle_event(in_item_t it);
      out_item_t r;
      int ch;
      int sum;
      int mins;
      logic [7:0] w;
      r  = '0;
      ch = int'(it.channel);
      if (it.action == ACT_CLEAR) begin
        if (ch == N_CH) begin
          foreach (credit_tenths[i]) credit_tenths[i] = '0;
          r.save_request = 1'b1;
        end else if (ch < N_CH) begin
          credit_tenths[ch] = '0;
          r.save_request = 1'b1;
        end
        return r;
      end
      // out-of-range channel: no state change, all fields zero
      if (ch >= N_CH) return r;
      case (it.action)
        ACT_ADD: begin
          sum = int'(credit_tenths[ch]) + int'(it.amount) * 10;
          credit_tenths[ch] = (sum > int'(TIME_CAP)) ? TIME_CAP : TIME_W'(sum);
          r.save_request = 1'b1;
        end
        ACT_METER: begin
          w = charge_weight(it);
          if (credit_tenths[ch] > TIME_W'(w)) begin
            credit_tenths[ch] = credit_tenths[ch] - TIME_W'(w);
          end else if (credit_tenths[ch] != '0) begin
            credit_tenths[ch] = '0;
            r.save_request = 1'b1;
          end
        end
        default: begin
          flash_count = flash_count + 8'd1;
          mins = int'(credit_tenths[ch]) / 10;
          if (it.fuse_ok) begin
            if (mins == 0) begin
              if (flash_count >= FLASH_PERIOD) begin
                flash_count = '0;
                r.glyph_hundreds = last_first_glyph[ch][6:0];
              end else if (flash_count >= FLASH_HALF) begin
                r.glyph_hundreds = ASCII_SPACE;
              end else begin
                r.glyph_hundreds = 7'(int'(ASCII_ZERO) + ch);
              end
              r.glyph_tens  = ASCII_SPACE;
              r.glyph_units = ASCII_SPACE;
            end else begin
              if (it.over_current && (flash_count <= 8'd2 ||
                  (flash_count >= 8'd5 && flash_count <= 8'd7))) begin
                r.glyph_hundreds = ASCII_SPACE;
                r.glyph_tens     = ASCII_SPACE;
                r.glyph_units    = ASCII_SPACE;
              end else begin
                r.glyph_hundreds = 7'(int'(ASCII_ZERO) + (mins / 100) % 10);
                r.glyph_tens     = 7'(int'(ASCII_ZERO) + (mins / 10) % 10);
                r.glyph_units    = 7'(int'(ASCII_ZERO) + mins % 10);
              end
              r.relay_on = 1'b1;
            end
          end else begin
            r.glyph_hundreds = ASCII_DASH;
            r.glyph_tens     = ASCII_DASH;
            r.glyph_units    = ASCII_DASH;
            if (credit_tenths[ch] != '0) begin
              credit_tenths[ch] = '0;
              r.save_request = 1'b1;
            end
          end
          last_first_glyph[ch] = {1'b0, r.glyph_hundreds};
        end
      endcase
      r.remaining_time = credit_tenths[ch];
      return r;
    endfunction

    function void note_input(in_item_t it);
      n_by_action[it.action]++;
      readouts_due.push_back(settle_event(it));
    endfunction

    function int pending();
      return readouts_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("MISMATCH @%0t result %0d: %s", $time, n_checked, msg);
    endtask

    task cmp(string field, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (readouts_due.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = readouts_due.pop_front();
      n_checked++;
      if (got.save_request) n_saves++;
      cmp("remaining_time", got.remaining_time, want.remaining_time);
      cmp("glyph_hundreds", got.glyph_hundreds, want.glyph_hundreds);
      cmp("glyph_tens", got.glyph_tens, want.glyph_tens);
      cmp("glyph_units", got.glyph_units, want.glyph_units);
      cmp("relay_on", got.relay_on, want.relay_on);
      cmp("save_request", got.save_request, want.save_request);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  meter_scoreboard meter = new();
  in_item_t        script [$];
  bit              tx_burst;
  bit              rx_burst;
  bit              long_hold;
  int              n_settings;

  multichannel_prepaid_time_meter #(.CHANNELS(N_CH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t ev(action_t a, int ch, int amt, bit fuse, bit over, int sample);
    in_item_t it;
    it.action         = a;
    it.channel        = 4'(ch);
    it.amount         = 10'(amt);
    it.fuse_ok        = fuse;
    it.over_current   = over;
    it.current_sample = 12'(sample);
    return it;
  endfunction

  function automatic in_item_t random_event();
    in_item_t it;
    int pick;
    int hi;
    pick = $urandom_range(0, 99);
    if (pick < 25)      it.action = ACT_ADD;
    else if (pick < 60) it.action = ACT_METER;
    else if (pick < 95) it.action = ACT_DISPLAY;
    else                it.action = ACT_CLEAR;
    if ($urandom_range(0, 19) == 0) it.channel = 4'($urandom_range(10, 15));
    else                            it.channel = 4'($urandom_range(0, N_CH - 1));
    if (it.action == ACT_CLEAR && $urandom_range(0, 2) == 0) it.channel = 4'(N_CH);
    // keep most credit small so metering reaches empty stores
    if ($urandom_range(0, 9) == 0) it.amount = 10'($urandom_range(0, 1023));
    else                           it.amount = 10'($urandom_range(0, 120));
    it.fuse_ok      = ($urandom_range(0, 19) != 0);
    it.over_current = ($urandom_range(0, 3) == 0);
    hi = 3 * int'(meter.cfg_base) + 2;
    if (hi > 4095) hi = 4095;
    if ($urandom_range(0, 1) == 0) it.current_sample = 12'($urandom_range(0, 4095));
    else                           it.current_sample = 12'($urandom_range(0, hi));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    meter.note_input(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic play_script();
    foreach (script[i]) send_item(script[i]);
    script.delete();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    meter.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (meter.pending() != 0) @(negedge clk);
  endtask

  // result sink: random back-pressure, one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (long_hold) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      meter.check_result(out_item);
      @(negedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    do @(posedge clk); while (rst);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: %0d cycles without a beat, %0d results outstanding",
             IDLE_LIMIT, meter.pending());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int base_pick;
    int mult_pick;
    logic [CFG_W-1:0] base_val;
    logic [7:0] mult_val;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tx_burst  = 1'b0;
    rx_burst  = 1'b0;
    long_hold = 1'b0;
    n_settings = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // plain time charging at reset settings
    script.push_back(ev(ACT_DISPLAY, 0, 0, 1, 0, 0));
    script.push_back(ev(ACT_ADD, 0, 999, 1, 0, 4095));
    script.push_back(ev(ACT_ADD, 0, 999, 1, 0, 0));
    script.push_back(ev(ACT_METER, 0, 0, 1, 0, 4095));
    script.push_back(ev(ACT_DISPLAY, 0, 0, 1, 1, 0));
    script.push_back(ev(ACT_DISPLAY, 0, 0, 1, 0, 0));
    script.push_back(ev(ACT_ADD, 1, 1, 1, 0, 0));
    script.push_back(ev(ACT_METER, 1, 0, 1, 0, 0));
    script.push_back(ev(ACT_METER, 1, 0, 1, 0, 0));
    // walk the empty-channel blink through a full flash period
    for (int i = 0; i < 7; i++) script.push_back(ev(ACT_DISPLAY, 2, 0, 1, 0, 0));
    script.push_back(ev(ACT_DISPLAY, 0, 0, 0, 0, 0));
    script.push_back(ev(ACT_ADD, 11, 999, 1, 1, 4095));
    script.push_back(ev(ACT_METER, 15, 1023, 1, 1, 4095));
    script.push_back(ev(ACT_DISPLAY, 12, 0, 1, 0, 0));
    script.push_back(ev(ACT_CLEAR, 15, 0, 1, 0, 0));
    script.push_back(ev(ACT_ADD, 5, 500, 1, 0, 0));
    script.push_back(ev(ACT_CLEAR, 5, 0, 1, 0, 0));
    script.push_back(ev(ACT_ADD, 6, 300, 1, 0, 0));
    script.push_back(ev(ACT_CLEAR, N_CH, 0, 1, 0, 0));
    play_script();
    wait_drained();

    write_reg(CFG_POWER_MODE, 12'd1);
    write_reg(CFG_BASE_CURRENT, 12'd100);
    write_reg(CFG_OC_MULTIPLE, 12'd3);
    n_settings++;
    script.push_back(ev(ACT_ADD, 4, 999, 1, 0, 0));
    script.push_back(ev(ACT_METER, 4, 0, 1, 1, 0));
    script.push_back(ev(ACT_METER, 4, 0, 1, 0, 4095));
    script.push_back(ev(ACT_METER, 4, 0, 1, 0, 100));
    script.push_back(ev(ACT_METER, 4, 0, 0, 0, 4095));
    script.push_back(ev(ACT_METER, 4, 0, 1, 0, 101));
    script.push_back(ev(ACT_DISPLAY, 4, 0, 1, 0, 0));
    play_script();
    wait_drained();

    // zero base current and zero multiple
    write_reg(CFG_BASE_CURRENT, 12'd0);
    write_reg(CFG_OC_MULTIPLE, 12'd0);
    n_settings++;
    script.push_back(ev(ACT_ADD, 7, 5, 1, 0, 0));
    script.push_back(ev(ACT_METER, 7, 0, 1, 1, 0));
    script.push_back(ev(ACT_METER, 7, 0, 1, 0, 4095));
    script.push_back(ev(ACT_ADD, 7, 2, 1, 0, 0));
    script.push_back(ev(ACT_METER, 7, 0, 1, 0, 0));
    play_script();
    wait_drained();

    write_reg(CFG_BASE_CURRENT, 12'd4095);
    write_reg(CFG_OC_MULTIPLE, 12'd255);
    n_settings++;
    script.push_back(ev(ACT_ADD, 8, 999, 1, 0, 0));
    script.push_back(ev(ACT_METER, 8, 0, 1, 1, 0));
    script.push_back(ev(ACT_METER, 8, 0, 1, 0, 4095));
    play_script();
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      base_pick = $urandom_range(0, 3);
      mult_pick = $urandom_range(0, 3);
      base_val = (base_pick == 0) ? 12'd1 : (base_pick == 1) ? 12'd4095 :
                 12'($urandom_range(10, 800));
      mult_val = (mult_pick == 0) ? 8'd0 : (mult_pick == 1) ? 8'd255 :
                 8'($urandom_range(1, 30));
      write_reg(CFG_POWER_MODE, (p % 3 == 2) ? 12'd0 : 12'd1);
      write_reg(CFG_BASE_CURRENT, base_val);
      write_reg(CFG_OC_MULTIPLE, 12'(mult_val));
      n_settings++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        // stall the sink long enough to back the block up
        if (p == 4 && i == 10) long_hold = 1'b1;
        // hold the source until everything in flight has come back
        if (p == 7 && i == 50) wait_drained();
        send_item(random_event());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (meter.pending() != 0)
      meter.report($sformatf("%0d expected results never arrived", meter.pending()));
    $display("Covered %0d beats (%0d add, %0d meter, %0d display, %0d clear) over %0d settings.",
             meter.n_by_action[0] + meter.n_by_action[1] + meter.n_by_action[2] +
             meter.n_by_action[3], meter.n_by_action[0], meter.n_by_action[1],
             meter.n_by_action[2], meter.n_by_action[3], n_settings);
    $display("Checked %0d results, %0d with save request, %0d mismatches.",
             meter.n_checked, meter.n_saves, meter.errors);
    if (meter.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
